>>> rtl/core/wdar_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the weekday alarm ring controller.
// No dependencies; every other file of the block uses it by scoped names.
package wdar_pkg;

    localparam int COUNT_W     = 11;
    localparam int PHASE_W     = 4;
    localparam int VOL_W       = 6;
    localparam int MAX_AMPS    = 8;
    localparam int BUZZ_TICKS  = 10 * 60 * 2;
    localparam int BEEP_PERIOD = 12;
    localparam int RAMP_TOP    = 32;
    localparam int RAMP_END    = 49;
    localparam int RAMP_BASE   = 9;
    localparam int MINUTE_SECS = 60;
    localparam int AMP_OFF     = 63;
    localparam int LAST_SECOND = 59;

    // Beep phase right after the ramp base has been loaded and stepped.
    localparam logic [PHASE_W-1:0] RAMP_PHASE = PHASE_W'((RAMP_BASE + 1) % BEEP_PERIOD);

    typedef enum logic [2:0] {
        ACT_ARM    = 3'd0,
        ACT_DISARM = 3'd1,
        ACT_CHECK  = 3'd2,
        ACT_TICK   = 3'd3,
        ACT_STOP   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        REG_HOUR    = 3'd0,
        REG_MINUTE  = 3'd1,
        REG_MASK    = 3'd2,
        REG_MODE    = 3'd3,
        REG_VOLUMES = 3'd4
    } reg_index_t;

    // Event payload, weekday in the lowest bits.
    typedef struct packed {
        logic [5:0] now_second;
        logic [5:0] now_minute;
        logic [4:0] now_hour;
        logic [2:0] weekday;
    } evt_t;

    // Result payload, armed in the lowest bit.
    typedef struct packed {
        logic [5:0] next_check_secs;
        logic       finished;
        logic       sound_stop;
        logic [4:0] amp_level;
        logic [7:0] amp_set_mask;
        logic       sound_start;
        logic       bright_now;
        logic       beep_now;
        logic       ringing;
        logic       armed;
    } result_t;

    typedef struct packed {
        logic               armed;
        logic               ringing;
        logic [COUNT_W-1:0] count;
        logic [PHASE_W-1:0] phase;   // count mod 12, kept alongside the count
    } state_t;

    typedef struct packed {
        logic [4:0]              hour;
        logic [5:0]              minute;
        logic [6:0]              day_mask;
        logic                    ring_mode;
        logic [MAX_AMPS*VOL_W-1:0] volumes;
    } cfg_t;

endpackage

>>> rtl/core/wdar_ring.sv
`timescale 1ns / 1ps
// Ring tick pattern: buzzer beeps/brightness or amplifier volume ramp.
// Depends on wdar_pkg.
module wdar_ring #(
    parameter int AMPLIFIERS = 8
) (
    input  wdar_pkg::cfg_t    cfg,
    input  wdar_pkg::state_t  state,
    output wdar_pkg::state_t  state_next,
    output wdar_pkg::result_t res
);

    logic                        start;
    logic [wdar_pkg::COUNT_W-1:0] base;
    logic [wdar_pkg::COUNT_W-1:0] cnt;
    logic [wdar_pkg::PHASE_W-1:0] phase_inc;
    logic [wdar_pkg::VOL_W-1:0]   vol;

    always_comb
    begin
        res        = '0;
        state_next = state;
        phase_inc  = (state.phase == wdar_pkg::PHASE_W'(wdar_pkg::BEEP_PERIOD - 1))
                     ? '0 : state.phase + 1'b1;
        start      = 1'b0;
        base       = state.count;
        cnt        = '0;
        vol        = '0;
        if (!cfg.ring_mode)
        begin
            // buzzer
            res.beep_now   = (state.phase == 4'd2) || (state.phase == 4'd4) ||
                             (state.phase == 4'd6) || (state.phase == 4'd8);
            res.bright_now = (state.count[2:0] == 3'd0);
            cnt            = state.count + 1'b1;
            state_next.count = cnt;
            state_next.phase = phase_inc;
            if (cnt >= wdar_pkg::COUNT_W'(wdar_pkg::BUZZ_TICKS))
            begin
                res.finished       = 1'b1;
                state_next.ringing = 1'b0;
                state_next.count   = '0;
                state_next.phase   = '0;
            end
        end
        else
        begin
            // volume ramp
            start = (state.count == '0);
            if (start)
            begin
                base = wdar_pkg::COUNT_W'(wdar_pkg::RAMP_BASE);
            end
            res.sound_start  = start;
            cnt              = base + 1'b1;
            state_next.count = cnt;
            state_next.phase = start ? wdar_pkg::RAMP_PHASE : phase_inc;
            if (cnt < wdar_pkg::COUNT_W'(wdar_pkg::RAMP_TOP))
            begin
                for (int i = 0; i < wdar_pkg::MAX_AMPS; i++)
                begin
                    vol = cfg.volumes[i*wdar_pkg::VOL_W +: wdar_pkg::VOL_W];
                    res.amp_set_mask[i] = (i < AMPLIFIERS) &&
                        (vol != wdar_pkg::VOL_W'(wdar_pkg::AMP_OFF)) &&
                        ({{(wdar_pkg::COUNT_W-wdar_pkg::VOL_W){1'b0}}, vol} >= cnt);
                end
                res.amp_level = cnt[4:0];
            end
            else if (cnt > wdar_pkg::COUNT_W'(wdar_pkg::RAMP_END))
            begin
                res.sound_stop     = 1'b1;
                res.finished       = 1'b1;
                state_next.ringing = 1'b0;
                state_next.count   = '0;
                state_next.phase   = '0;
            end
        end
        res.armed   = state_next.armed;
        res.ringing = state_next.ringing;
    end

endmodule

>>> rtl/core/wdar_step.sv
`timescale 1ns / 1ps
// Event decode: arm, disarm, time check, ring tick, user stop.
// Depends on wdar_pkg and wdar_ring.
module wdar_step #(
    parameter int AMPLIFIERS = 8
) (
    input  logic [2:0]        action,
    input  wdar_pkg::evt_t    evt,
    input  wdar_pkg::cfg_t    cfg,
    input  wdar_pkg::state_t  state,
    output wdar_pkg::state_t  state_next,
    output wdar_pkg::result_t res
);

    wdar_pkg::state_t  ring_state;
    wdar_pkg::result_t ring_res;

    logic [7:0] mask_ext;
    logic [2:0] day_idx;
    logic       day_hit;
    logic       once;
    logic [5:0] sec_clip;

    wdar_ring #(
        .AMPLIFIERS (AMPLIFIERS)
    ) u_ring (
        .cfg        (cfg),
        .state      (state),
        .state_next (ring_state),
        .res        (ring_res)
    );

    always_comb
    begin
        state_next = state;
        res        = '0;
        mask_ext   = {1'b0, cfg.day_mask};
        day_idx    = 3'd7 - evt.weekday;
        day_hit    = (evt.weekday != 3'd0) && mask_ext[day_idx];
        once       = !day_hit && (cfg.day_mask == '0);
        sec_clip   = (evt.now_second > 6'(wdar_pkg::LAST_SECOND))
                     ? 6'(wdar_pkg::LAST_SECOND) : evt.now_second;
        case (action)
            wdar_pkg::ACT_ARM:
            begin
                state_next.armed = 1'b1;
            end
            wdar_pkg::ACT_DISARM:
            begin
                state_next.armed = 1'b0;
            end
            wdar_pkg::ACT_CHECK:
            begin
                if (state.armed)
                begin
                    if ((day_hit || once) && (evt.now_hour == cfg.hour) &&
                        (evt.now_minute == cfg.minute))
                    begin
                        state_next.ringing = 1'b1;
                        state_next.count   = '0;
                        state_next.phase   = '0;
                        if (once)
                        begin
                            state_next.armed = 1'b0;
                        end
                    end
                    if (state_next.armed)
                    begin
                        res.next_check_secs = 6'(wdar_pkg::MINUTE_SECS) - sec_clip;
                    end
                end
            end
            wdar_pkg::ACT_TICK:
            begin
                if (state.ringing)
                begin
                    state_next = ring_state;
                    res        = ring_res;
                end
            end
            wdar_pkg::ACT_STOP:
            begin
                if (state.ringing)
                begin
                    state_next.ringing = 1'b0;
                    state_next.count   = '0;
                    state_next.phase   = '0;
                    res.finished       = 1'b1;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
        res.armed   = state_next.armed;
        res.ringing = state_next.ringing;
    end

endmodule

>>> rtl/core/weekday_alarm_ring_controller_unit.sv
`timescale 1ns / 1ps
// Weekday alarm ring controller: every request on the slave stream gives exactly one
// result on the master stream, one request per clock sustained while the master side
// takes results. A request is held in the input register, then a single pass of
// compare/counter logic updates the alarm state and loads the result register, so the
// rate is set only by the master side taking results. The input register refills in
// the cycle its request moves on. Configuration writes go straight to the setting
// registers and must only be made while no request is in flight.
// Depends on wdar_pkg, wdar_step and wdar_ring.
module weekday_alarm_ring_controller_unit #(
    parameter int AMPLIFIERS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // weekday[2:0], now_hour[7:3], now_minute[13:8],
                                   // now_second[19:14], zero fill
    input  logic [2:0]  s_tuser,   // action[2:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // armed[0], ringing[1], beep_now[2], bright_now[3],
                                   // sound_start[4], amp_set_mask[12:5],
                                   // amp_level[17:13], sound_stop[18], finished[19],
                                   // next_check_secs[25:20], zero fill
);

    wdar_pkg::cfg_t    cfg_reg,   cfg_next;
    wdar_pkg::state_t  state_reg, state_next;
    wdar_pkg::evt_t    evt_reg;
    logic [2:0]        action_reg;
    logic              in_valid_reg;
    wdar_pkg::result_t res;
    wdar_pkg::result_t res_reg;
    logic              out_valid_reg;
    logic              advance;

    // The stored request moves on whenever the result register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, res_reg};

    wdar_step #(
        .AMPLIFIERS (AMPLIFIERS)
    ) u_step (
        .action     (action_reg),
        .evt        (evt_reg),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (res)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                wdar_pkg::REG_HOUR:    cfg_next.hour      = cfg_data[4:0];
                wdar_pkg::REG_MINUTE:  cfg_next.minute    = cfg_data[5:0];
                wdar_pkg::REG_MASK:    cfg_next.day_mask  = cfg_data[6:0];
                wdar_pkg::REG_MODE:    cfg_next.ring_mode = cfg_data[0];
                wdar_pkg::REG_VOLUMES: cfg_next.volumes   = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{hour: '0, minute: '0, day_mask: '0, ring_mode: 1'b0,
                               volumes: '1};
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            evt_reg    <= s_tdata[19:0];
            action_reg <= s_tuser;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

endmodule

>>> tb/tb_weekday_alarm_ring_controller_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for weekday_alarm_ring_controller_unit: directed and random event
// streams, results checked against an in-bench alarm model. Depends on wdar_pkg and the RTL.

class alarm_outcome_board;
    localparam int BUZZ_LEN    = 10 * 60 * 2;
    localparam int BEEP_PERIOD = 12;
    localparam int BRIGHT_EVERY = 8;
    localparam int RAMP_TOP    = 32;
    localparam int RAMP_END    = 49;
    localparam int RAMP_BASE   = 9;
    localparam int MINUTE_SECS = 60;
    localparam int LAST_SECOND = 59;
    localparam int AMP_OFF     = 63;
    localparam int REPORT_CAP  = 100;

    // settings copy
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [6:0]  day_mask;
    logic        ring_mode;
    logic [47:0] volumes;

    // alarm state
    bit          armed;
    bit          ringing;
    bit          one_shot;
    logic [10:0] count;

    wdar_pkg::result_t alarm_outcomes[$];
    int amps;
    int mismatches, results_seen, requests_seen;
    int rings_started, buzz_timeouts, ramp_ends, user_stops;

    function new(int n_amps);
        amps = n_amps;
        hour = '0;
        minute = '0;
        day_mask = '0;
        ring_mode = 1'b0;
        volumes = '1;
        armed = 0;
        ringing = 0;
        one_shot = 0;
        count = '0;
        mismatches = 0;
        results_seen = 0;
        requests_seen = 0;
        rings_started = 0;
        buzz_timeouts = 0;
        ramp_ends = 0;
        user_stops = 0;
    endfunction

    function void set_reg(wdar_pkg::reg_index_t idx, logic [47:0] value);
        case (idx)
            wdar_pkg::REG_HOUR:    hour = value[4:0];
            wdar_pkg::REG_MINUTE:  minute = value[5:0];
            wdar_pkg::REG_MASK:    day_mask = value[6:0];
            wdar_pkg::REG_MODE:    ring_mode = value[0];
            wdar_pkg::REG_VOLUMES: volumes = value;
            default: ;
        endcase
    endfunction

    function int pending();
        return alarm_outcomes.size();
    endfunction

    function void end_ring(inout wdar_pkg::result_t r);
        ringing = 0;
        count = '0;
        r.finished = 1'b1;
    endfunction

    // Advance the alarm by one accepted request and queue the result it must give.
    function void note_request(logic [2:0] act, wdar_pkg::evt_t ev);
        wdar_pkg::result_t r;
        logic [5:0]  sec;
        logic [5:0]  vol;
        logic [10:0] c;
        bit          day_hit;
        bit          once;
        r = '0;
        requests_seen++;
        case (act)
            wdar_pkg::ACT_ARM:    armed = 1;
            wdar_pkg::ACT_DISARM: armed = 0;
            wdar_pkg::ACT_CHECK:
                if (armed)
                begin
                    // weekday 1 is Monday on mask bit 6; weekday 0 hits no bit
                    day_hit = (ev.weekday == 3'd0) ? 1'b0 : day_mask[3'd7 - ev.weekday];
                    once = 0;
                    if (!day_hit && day_mask == '0)
                    begin
                        day_hit = 1;
                        once = 1;
                    end
                    if (day_hit && ev.now_hour == hour && ev.now_minute == minute)
                    begin
                        ringing = 1;
                        count = '0;
                        one_shot = once;
                        rings_started++;
                        if (once)
                            armed = 0;
                    end
                    if (armed)
                    begin
                        sec = (ev.now_second > LAST_SECOND) ? 6'(LAST_SECOND) : ev.now_second;
                        r.next_check_secs = 6'(MINUTE_SECS - sec);
                    end
                end
            wdar_pkg::ACT_TICK:
                if (ringing && ring_mode == 1'b0)
                begin
                    c = count;
                    r.beep_now = ((c % BEEP_PERIOD) inside {2, 4, 6, 8});
                    r.bright_now = (c % BRIGHT_EVERY == 0);
                    c = c + 11'd1;
                    count = c;
                    if (c >= BUZZ_LEN)
                    begin
                        end_ring(r);
                        buzz_timeouts++;
                    end
                end
                else if (ringing)
                begin
                    c = count;
                    if (c == '0)
                    begin
                        r.sound_start = 1'b1;
                        c = 11'(RAMP_BASE);
                    end
                    c = c + 11'd1;
                    count = c;
                    if (c < RAMP_TOP)
                    begin
                        for (int i = 0; i < amps && i < 8; i++)
                        begin
                            vol = volumes[6*i +: 6];
                            if (vol != AMP_OFF && vol >= c)
                                r.amp_set_mask[i] = 1'b1;
                        end
                        r.amp_level = c[4:0];
                    end
                    else if (c > RAMP_END)
                    begin
                        r.sound_stop = 1'b1;
                        end_ring(r);
                        ramp_ends++;
                    end
                end
            wdar_pkg::ACT_STOP:
                if (ringing)
                begin
                    end_ring(r);
                    user_stops++;
                end
            default: ;
        endcase
        r.armed = armed;
        r.ringing = ringing;
        alarm_outcomes.push_back(r);
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
                                      results_seen, name, got, want));
    endtask

    task check_result(logic [31:0] word);
        wdar_pkg::result_t got;
        wdar_pkg::result_t want;
        got = word[25:0];
        results_seen++;
        if (alarm_outcomes.size() == 0)
        begin
            report_mismatch($sformatf("result %0d (%h) arrived with no request pending",
                                      results_seen, word));
            return;
        end
        want = alarm_outcomes.pop_front();
        if (word[31:26] !== '0)
            report_mismatch($sformatf("result %0d: fill bits %b not zero",
                                      results_seen, word[31:26]));
        compare_field("armed", got.armed, want.armed);
        compare_field("ringing", got.ringing, want.ringing);
        compare_field("beep_now", got.beep_now, want.beep_now);
        compare_field("bright_now", got.bright_now, want.bright_now);
        compare_field("sound_start", got.sound_start, want.sound_start);
        compare_field("amp_set_mask", got.amp_set_mask, want.amp_set_mask);
        compare_field("amp_level", got.amp_level, want.amp_level);
        compare_field("sound_stop", got.sound_stop, want.sound_stop);
        compare_field("finished", got.finished, want.finished);
        compare_field("next_check_secs", got.next_check_secs, want.next_check_secs);
    endtask
endclass

module tb_weekday_alarm_ring_controller_unit;

    localparam int AMPS        = 8;
    localparam int CYCLE_LIMIT = 500000;  // watchdog bound on the whole run
    localparam int RAND_ITEMS  = 250;     // random share; the long buzzer ring adds ~1200
    localparam int PHASES      = 9;       // three setting phases per idling mix
    localparam int ACT_COUNT   = 5;       // action codes at and above this are unused
    localparam int LONG_PHASE  = 4;       // phase that runs one buzzer ring to its timeout

    // Every input has a known value from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // weekday[2:0], now_hour[7:3], now_minute[13:8],
                                  // now_second[19:14], zero fill
    logic [2:0]  s_tuser = '0;    // action[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // armed, ringing, beep_now, bright_now, sound_start,
                                  // amp_set_mask, amp_level, sound_stop, finished,
                                  // next_check_secs, zero fill

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int items_sent = 0;
    int cycles = 0;

    alarm_outcome_board board;

    weekday_alarm_ring_controller_unit #(
        .AMPLIFIERS(AMPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #10 clk = ~clk;

    // Receiver: stalls at random, rate set by the current idling mix.
    always @(posedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    // Both handshakes are sampled at the edge that completes them; values read here
    // are the ones from before the edge, so the order of processes does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, wdar_pkg::evt_t'(s_tdata[19:0]));
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("weekday_alarm_ring_controller_unit: mismatch");
            $finish;
        end
    end

    function automatic wdar_pkg::evt_t make_evt(logic [2:0] wd, logic [4:0] h,
                                                logic [5:0] m, logic [5:0] s);
        wdar_pkg::evt_t ev;
        ev.weekday = wd;
        ev.now_hour = h;
        ev.now_minute = m;
        ev.now_second = s;
        return ev;
    endfunction

    // Time check that hits the current settings: weekday from the enabled days,
    // any weekday when the mask is empty (one-shot).
    function automatic wdar_pkg::evt_t match_evt();
        logic [2:0] wd;
        wd = 3'($urandom_range(7));
        if (board.day_mask != '0)
            while (wd == 3'd0 || !board.day_mask[3'd7 - wd])
                wd = 3'($urandom_range(1, 7));
        return make_evt(wd, board.hour, board.minute, 6'($urandom_range(63)));
    endfunction

    // Present one request, with a random gap first; returns at the accepting edge.
    task automatic send_request(logic [2:0] act, wdar_pkg::evt_t ev);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {4'b0000, ev};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold the sender until every queued result is back. The first edge lets the
    // request accepted at the last edge reach the board.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(wdar_pkg::reg_index_t idx, logic [47:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        board.set_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Every result carries one request, so an empty queue means the block is idle.
    task automatic write_settings(logic [4:0] h, logic [5:0] m, logic [6:0] mask,
                                  logic mode, logic [47:0] vols);
        drain();
        write_reg(wdar_pkg::REG_HOUR, 48'(h));
        write_reg(wdar_pkg::REG_MINUTE, 48'(m));
        write_reg(wdar_pkg::REG_MASK, 48'(mask));
        write_reg(wdar_pkg::REG_MODE, 48'(mode));
        write_reg(wdar_pkg::REG_VOLUMES, vols);
    endtask

    initial
    begin
        int phase;
        int phase_end;
        int burst;
        int k;
        int pick;
        logic [47:0] vols;
        wdar_pkg::evt_t ev;

        board = new(AMPS);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Reset values, written explicitly: empty mask, so any match is a one-shot.
        write_settings(5'd0, 6'd0, 7'd0, 1'b0, '1);
        send_request(wdar_pkg::ACT_TICK, '0);             // tick while idle: ignored
        send_request(wdar_pkg::ACT_STOP, '0);             // stop while idle: ignored
        send_request(3'(ACT_COUNT), '1);                  // unused codes
        send_request(3'(ACT_COUNT + 2), '1);
        // disarmed: no match
        send_request(wdar_pkg::ACT_CHECK, make_evt(3'd7, 5'd0, 6'd0, 6'd0));
        send_request(wdar_pkg::ACT_ARM, '0);
        // second past 59
        send_request(wdar_pkg::ACT_CHECK, make_evt(3'd0, 5'd5, 6'd0, 6'd63));
        // one-shot match
        send_request(wdar_pkg::ACT_CHECK, make_evt(3'd0, 5'd0, 6'd0, 6'd30));
        send_request(wdar_pkg::ACT_TICK, '0);
        send_request(wdar_pkg::ACT_TICK, '0);
        send_request(wdar_pkg::ACT_TICK, '0);
        send_request(wdar_pkg::ACT_DISARM, '0);           // ringing goes on
        send_request(wdar_pkg::ACT_TICK, '0);
        send_request(wdar_pkg::ACT_STOP, '0);
        send_request(wdar_pkg::ACT_STOP, '0);

        // All days, latest time, ramp mode; amps 0..7 targets 0, 9, 10, 31, 32, 62,
        // off and 11 so every ramp compare edge shows up.
        write_settings(5'd23, 6'd59, 7'h7F, 1'b1,
                       {6'd11, 6'd63, 6'd62, 6'd32, 6'd31, 6'd10, 6'd9, 6'd0});
        send_request(wdar_pkg::ACT_ARM, '0);
        send_request(wdar_pkg::ACT_CHECK, make_evt(3'd7, 5'd23, 6'd59, 6'd0));
        send_request(wdar_pkg::ACT_TICK, '0);             // sound start
        send_request(wdar_pkg::ACT_TICK, '0);
        // restart while ringing
        send_request(wdar_pkg::ACT_CHECK, make_evt(3'd1, 5'd23, 6'd59, 6'd59));
        send_request(wdar_pkg::ACT_TICK, '0);
        // switch to buzzer with the ramp count still live
        write_settings(5'd23, 6'd59, 7'h7F, 1'b0, '1);
        send_request(wdar_pkg::ACT_TICK, '0);
        send_request(wdar_pkg::ACT_TICK, '0);
        send_request(wdar_pkg::ACT_STOP, '0);

        // ---- random part ----
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase / 3)
                0:
                begin
                    send_idle_pct = 21;
                    recv_idle_pct = 78;
                end
                1:
                begin
                    send_idle_pct = 78;
                    recv_idle_pct = 21;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            vols = {16'($urandom), 32'($urandom)};
            if (phase == 0)
                write_settings(5'd0, 6'd0, 7'd0, 1'b0, '1);
            else if (phase == 1)
                write_settings('1, '1, '1, 1'b1, '0);
            else
                write_settings(5'($urandom_range(23)), 6'($urandom_range(59)),
                               ($urandom_range(3) == 0) ? 7'd0 : 7'($urandom),
                               (phase == LONG_PHASE) ? 1'b0 : 1'($urandom), vols);

            // One buzzer ring held to its full length, plus a tick after the end.
            if (phase == LONG_PHASE)
            begin
                send_request(wdar_pkg::ACT_ARM, wdar_pkg::evt_t'($urandom));
                send_request(wdar_pkg::ACT_CHECK, match_evt());
                repeat (wdar_pkg::BUZZ_TICKS + 1)
                    send_request(wdar_pkg::ACT_TICK, wdar_pkg::evt_t'($urandom));
            end

            phase_end = items_sent + RAND_ITEMS / PHASES;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(99);
                if (pick < 2)
                begin
                    drain();
                end
                else if (pick < 35)
                begin
                    // noise: any code, any field bits
                    send_request(3'($urandom_range(7)), wdar_pkg::evt_t'($urandom));
                end
                else
                begin
                    // maybe arm, maybe a near miss, a hit, then a run of mostly ticks, maybe a stop
                    if ($urandom_range(9) != 0)
                        send_request(wdar_pkg::ACT_ARM, wdar_pkg::evt_t'($urandom));
                    if ($urandom_range(3) == 0)
                    begin
                        ev = match_evt();
                        ev.now_minute = ev.now_minute ^ 6'(1 << $urandom_range(5));
                        send_request(wdar_pkg::ACT_CHECK, ev);
                    end
                    send_request(wdar_pkg::ACT_CHECK, match_evt());
                    burst = board.ring_mode ? $urandom_range(1, 45) : $urandom_range(1, 40);
                    for (k = 0; k < burst; k++)
                    begin
                        pick = $urandom_range(99);
                        if (pick < 3)
                            send_request(wdar_pkg::ACT_DISARM, wdar_pkg::evt_t'($urandom));
                        else if (pick < 5)
                            send_request(wdar_pkg::ACT_CHECK, match_evt());
                        else if (pick < 8)
                            send_request(3'($urandom_range(7)), wdar_pkg::evt_t'($urandom));
                        else
                            send_request(wdar_pkg::ACT_TICK, wdar_pkg::evt_t'($urandom));
                    end
                    if ($urandom_range(2) == 0)
                        send_request(wdar_pkg::ACT_STOP, wdar_pkg::evt_t'($urandom));
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d requests in %0d setting phases under three idling mixes,",
                 board.requests_seen, PHASES);
        $display("%0d results checked; rings %0d, buzzer timeouts %0d, ramps %0d, stops %0d.",
                 board.results_seen, board.rings_started, board.buzz_timeouts,
                 board.ramp_ends, board.user_stops);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("weekday_alarm_ring_controller_unit: match");
        else
            $display("weekday_alarm_ring_controller_unit: mismatch");
        $finish;
    end
endmodule

>>> weekday_alarm_ring_controller_unit.f
rtl/core/wdar_pkg.sv
rtl/core/wdar_ring.sv
rtl/core/wdar_step.sv
rtl/core/weekday_alarm_ring_controller_unit.sv
tb/tb_weekday_alarm_ring_controller_unit.sv
